// File: hdl/ialu_pkg.sv
// package for the integer alu: operation and status codes, queue entry type
// no dependencies
package ialu_pkg;
	localparam int WIDTH = 32;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		FUNC_ADD = 3'd0,
		FUNC_SUB = 3'd1,
		FUNC_MUL = 3'd2,
		FUNC_DIV = 3'd3,
		FUNC_REM = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_RULE        = 2'd1,
		ST_UNSUPPORTED = 2'd2
	} status_t;

	// operation class decided in the front end
	typedef enum logic [1:0] {
		CL_ADDSUB = 2'd0,
		CL_MUL    = 2'd1,
		CL_DIV    = 2'd2,
		CL_NONE   = 2'd3
	} class_t;

	typedef struct packed {
		class_t            cls;
		logic              sub;
		logic              rem;
		logic [1:0]        status;
		logic [WIDTH-1:0]  a;
		logic [WIDTH-1:0]  b;
	} entry_t;
endpackage

// File: hdl/ialu_front.sv
// front end: accepts items, classifies them, and queues them for the back end
// depends on ialu_pkg
module ialu_front import ialu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        func,
	input  logic [WIDTH-1:0]  operand_a,
	input  logic [WIDTH-1:0]  operand_b,
	output logic              q_valid,
	input  logic              q_ready,
	output entry_t            q_data
);
	entry_t           mem_q [QDEPTH];
	logic [QAW-1:0]   wptr_q, rptr_q;
	logic [QAW:0]     count_q;
	entry_t           ent;
	logic             push, pop;

	// classify the incoming operation
	always_comb begin
		ent = '0;
		ent.a = operand_a;
		ent.b = operand_b;
		ent.status = ST_OK;
		unique case (func) inside
			FUNC_ADD: ent.cls = CL_ADDSUB;
			FUNC_SUB: begin
				ent.cls = CL_ADDSUB;
				ent.sub = 1'b1;
			end
			FUNC_MUL: ent.cls = CL_MUL;
			FUNC_DIV, FUNC_REM: begin
				ent.cls = CL_DIV;
				ent.rem = (func == FUNC_REM);
				if (operand_b == '0) begin
					ent.cls = CL_NONE;
					ent.status = ST_RULE;
				end
			end
			default: begin
				ent.cls = CL_NONE;
				ent.status = ST_UNSUPPORTED;
			end
		endcase
	end

	assign in_ready = (count_q != QDEPTH[QAW:0]);
	assign q_valid = (count_q != '0);
	assign q_data = mem_q[rptr_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= ent;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			count_q <= count_q + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
		end
	end
endmodule

// File: hdl/ialu_back.sv
// back end: pipelined execution, one radix-2 divide step per divide stage
// depends on ialu_pkg
module ialu_back import ialu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  entry_t            q_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WIDTH-1:0]  result,
	output logic [1:0]        status
);
	localparam int NS = WIDTH + 2;

	// per-stage pipeline contents
	logic              v_s   [1:NS];
	class_t            cls_s [1:NS];
	logic              rem_s [1:NS];
	logic              qneg_s[1:NS];
	logic              rneg_s[1:NS];
	logic [1:0]        st_s  [1:NS];
	logic [WIDTH-1:0]  res_s [1:NS];
	logic [WIDTH-1:0]  num_s [1:NS];
	logic [WIDTH-1:0]  den_s [1:NS];
	logic [WIDTH:0]    par_s [1:NS];

	logic adv;
	assign adv = !v_s[NS] || out_ready;
	assign q_ready = adv;

	// stage 1: add/sub, multiply, divide operand magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[1] <= 1'b0;
		else if (adv) v_s[1] <= q_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s[1] <= q_data.cls;
			rem_s[1] <= q_data.rem;
			st_s[1] <= q_data.status;
			qneg_s[1] <= q_data.a[WIDTH-1] ^ q_data.b[WIDTH-1];
			rneg_s[1] <= q_data.a[WIDTH-1];
			num_s[1] <= q_data.a[WIDTH-1] ? -q_data.a : q_data.a;
			den_s[1] <= q_data.b[WIDTH-1] ? -q_data.b : q_data.b;
			par_s[1] <= '0;
			case (q_data.cls)
				CL_ADDSUB: res_s[1] <= q_data.sub ? q_data.a - q_data.b
				                                  : q_data.a + q_data.b;
				CL_MUL: res_s[1] <= q_data.a * q_data.b;
				default: res_s[1] <= '0;
			endcase
		end
	end

	// divide steps: shift one dividend bit into the partial remainder
	for (genvar i = 1; i <= WIDTH; i++) begin : g_step
		logic [WIDTH:0] trial;
		logic [WIDTH:0] diff;
		assign trial = {par_s[i][WIDTH-1:0], num_s[i][WIDTH-1]};
		assign diff = trial - {1'b0, den_s[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else if (adv) v_s[i+1] <= v_s[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				cls_s[i+1] <= cls_s[i];
				rem_s[i+1] <= rem_s[i];
				st_s[i+1] <= st_s[i];
				qneg_s[i+1] <= qneg_s[i];
				rneg_s[i+1] <= rneg_s[i];
				den_s[i+1] <= den_s[i];
				res_s[i+1] <= res_s[i];
				par_s[i+1] <= diff[WIDTH] ? trial : diff;
				num_s[i+1] <= {num_s[i][WIDTH-2:0], ~diff[WIDTH]};
			end
		end
	end

	// last stage: sign fix and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[NS] <= 1'b0;
		else if (adv) v_s[NS] <= v_s[NS-1];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s[NS] <= cls_s[NS-1];
			rem_s[NS] <= rem_s[NS-1];
			qneg_s[NS] <= qneg_s[NS-1];
			rneg_s[NS] <= rneg_s[NS-1];
			num_s[NS] <= num_s[NS-1];
			den_s[NS] <= den_s[NS-1];
			par_s[NS] <= par_s[NS-1];
			st_s[NS] <= st_s[NS-1];
			if (cls_s[NS-1] == CL_DIV) begin
				if (rem_s[NS-1])
					res_s[NS] <= rneg_s[NS-1] ? -par_s[NS-1][WIDTH-1:0]
					                          : par_s[NS-1][WIDTH-1:0];
				else
					res_s[NS] <= qneg_s[NS-1] ? -num_s[NS-1] : num_s[NS-1];
			end else begin
				res_s[NS] <= res_s[NS-1];
			end
		end
	end

	assign out_valid = v_s[NS];
	assign result = res_s[NS];
	assign status = st_s[NS];
endmodule

// File: hdl/integer_alu_with_divide.sv
// top level of the integer alu: front end, queue, pipelined back end
// depends on ialu_pkg, ialu_front, ialu_back
//
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    func, operand_a, operand_b
// out       output     out_valid/out_ready  result, status
//
// one item per cycle sustained unless the output stalls; the path from input to
// output holds queue storage, a first stage, WIDTH divide stages of one quotient
// bit each, and one sign fix stage. every operation shares the pipeline so
// results stay in order. reset clears the queue pointers and stage valid bits.
// an output stall freezes the pipeline; the queue absorbs up to four items.
module integer_alu_with_divide import ialu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        func,
	input  logic [WIDTH-1:0]  operand_a,
	input  logic [WIDTH-1:0]  operand_b,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WIDTH-1:0]  result,
	output logic [1:0]        status
);
	logic   q_valid, q_ready;
	entry_t q_data;

	ialu_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .func, .operand_a, .operand_b,
		.q_valid, .q_ready, .q_data
	);

	ialu_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_data,
		.out_valid, .out_ready, .result, .status
	);
endmodule

// File: hdl/ialu_checker.sv
// port-level checks for the integer alu
// depends on ialu_pkg; bound to integer_alu_with_divide
module ialu_checker import ialu_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [WIDTH-1:0]  result,
	input logic [1:0]        status
);
	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result) && $stable(status))
		else $error("output changed while stalled");

	// error results carry zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> result == '0)
		else $error("nonzero result with error status");

	// status code is never beyond the defined codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_UNSUPPORTED)
		else $error("bad status code");
endmodule

bind integer_alu_with_divide ialu_checker u_checker (
	.clk, .arst_n, .out_valid, .out_ready, .result, .status
);

// File: tb/tb_checker.sv
// checker for the integer alu: watches both channels, predicts each result, compares in order
// depends on ialu_pkg
module tb_checker import ialu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [2:0]        func,
	input  logic [WIDTH-1:0]  operand_a,
	input  logic [WIDTH-1:0]  operand_b,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [WIDTH-1:0]  result,
	input  logic [1:0]        status,
	output int                fail_count,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [WIDTH-1:0] value;
		logic [1:0]       st;
	} alu_out_t;

	alu_out_t expected_q[$];

	// compute the expected result of one operation
	function automatic alu_out_t alu_predict(logic [2:0] op, logic [WIDTH-1:0] a,
		logic [WIDTH-1:0] b);
		alu_out_t r;
		logic [WIDTH-1:0] ma, mb, q, m;
		r.value = '0;
		r.st = ST_OK;
		ma = a[WIDTH-1] ? -a : a;
		mb = b[WIDTH-1] ? -b : b;
		case (op)
			FUNC_ADD: r.value = a + b;
			FUNC_SUB: r.value = a - b;
			FUNC_MUL: r.value = a * b;
			FUNC_DIV, FUNC_REM: begin
				if (b == '0) begin
					r.st = ST_RULE;
				end else if (op == FUNC_DIV) begin
					q = ma / mb;
					r.value = (a[WIDTH-1] != b[WIDTH-1]) ? -q : q;
				end else begin
					m = ma % mb;
					r.value = a[WIDTH-1] ? -m : m;
				end
			end
			default: r.st = ST_UNSUPPORTED;
		endcase
		return r;
	endfunction

	assign pending = expected_q.size();

	// predict on input transfer, compare on output transfer
	always @(posedge clk or negedge arst_n) begin
		alu_out_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %h status %0d", $time, result, status);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (e.value !== result || e.st !== status) begin
						$display("%0t: mismatch expected %h/%0d actual %h/%0d", $time,
							e.value, e.st, result, status);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(alu_predict(func, operand_a, operand_b));
		end
	end
endmodule

// File: tb/tb_top.sv
// testbench top for the integer alu: stimulus, idling, hold-off and verdict
// depends on ialu_pkg, integer_alu_with_divide, tb_checker
module tb_top import ialu_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NRAND = 1600;
	localparam logic [WIDTH-1:0] MINV = {1'b1, {(WIDTH-1){1'b0}}};
	localparam logic [WIDTH-1:0] MAXV = {1'b0, {(WIDTH-1){1'b1}}};

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [2:0] func = '0;
	logic [WIDTH-1:0] operand_a = '0, operand_b = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [WIDTH-1:0] result;
	logic [1:0] status;
	int fail_count, pending;
	bit calm = 0;
	bit hold_off = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	integer_alu_with_divide u_top (.*);
	tb_checker u_chk (.*);

	// random operand with bias toward edge values
	function automatic logic [WIDTH-1:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return MINV;
			1: return MAXV;
			2: return '0;
			3: return '1;
			4: return WIDTH'(1);
			5: return $signed(WIDTH'($urandom_range(0, 40))) - WIDTH'(20);
			default: return WIDTH'({$urandom, $urandom});
		endcase
	endfunction

	// one transfer on the input channel, with an optional idle burst first
	task automatic send(logic [2:0] op, logic [WIDTH-1:0] a, logic [WIDTH-1:0] b);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		func <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// receiver: random stall bursts, long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_ready <= 0;
				for (n = 0; n < 200; n++) @(posedge clk);
				hold_off = 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_ready <= 1;
				@(posedge clk);
			end
		end
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int i, k;
		logic [2:0] op;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, every code, zero divisor, minimum over minus one
		send(FUNC_ADD, MAXV, 1);
		send(FUNC_SUB, MINV, 1);
		send(FUNC_MUL, MAXV, MAXV);
		send(FUNC_MUL, MINV, '1);
		send(FUNC_DIV, MINV, '1);
		send(FUNC_REM, MINV, '1);
		send(FUNC_DIV, 7, 0);
		send(FUNC_REM, MINV, 0);
		send(FUNC_DIV, -7, 2);
		send(FUNC_REM, -7, 2);
		send(FUNC_DIV, 7, -2);
		send(FUNC_REM, 7, -2);
		send(FUNC_DIV, MAXV, MINV);
		send(FUNC_REM, MINV, MAXV);
		send(3'd5, 1, 1);
		send(3'd6, '1, '1);
		send(3'd7, MINV, MAXV);
		send(FUNC_ADD, '1, '1);
		send(FUNC_SUB, '0, MINV);
		// long receiver hold-off while input keeps offering
		hold_off = 1;
		for (k = 0; k < 30; k++)
			send(FUNC_ADD, WIDTH'({$urandom, $urandom}), WIDTH'({$urandom, $urandom}));
		for (i = 0; i < NRAND; i++) begin
			if (i == NRAND - 200) calm = 1;
			op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			send(op, pick_operand(), pick_operand());
		end
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (WIDTH + 10) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
